### rtl/core/crt_pkg.sv
// Package for the cascaded reload timer core: widths, register codes,
// controller state, and the command/status structs shared by all modules.
// No dependencies.
`default_nettype none

package crt_pkg;

   localparam int DEFAULT_TIMER_COUNT = 4;

   localparam int COUNT_W    = 16;
   localparam int PRESCALE_W = 11;
   localparam int SUM_W      = PRESCALE_W + 1;   // prescale count plus one item's cycles
   localparam int CYCLES_W   = 7;
   localparam int CTRL_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int IRQ_W      = 4;
   localparam int SOUND_W    = 2;
   localparam int SHIFT_W    = 4;

   // control register bit positions
   localparam int CTRL_SEL_LO  = 0;
   localparam int CTRL_SEL_HI  = 1;
   localparam int CTRL_CASCADE = 2;
   localparam int CTRL_IRQ     = 3;
   localparam int CTRL_START   = 4;

   localparam logic [COUNT_W-1:0] MAX_COUNT = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RELOAD_ZERO   = 3'd0,
      REG_RELOAD_ONE    = 3'd1,
      REG_RELOAD_TWO    = 3'd2,
      REG_RELOAD_THREE  = 3'd3,
      REG_CONTROL_ZERO  = 3'd4,
      REG_CONTROL_ONE   = 3'd5,
      REG_CONTROL_TWO   = 3'd6,
      REG_CONTROL_THREE = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      PSC_DIV1    = 2'd0,
      PSC_DIV64   = 2'd1,
      PSC_DIV256  = 2'd2,
      PSC_DIV1024 = 2'd3
   } prescale_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WRAP,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic begin_item;   // latch cycles, clear masks, select timer 0
      logic setup;        // start handling and prescale add for current timer
      logic step;         // one counter advance / wrap iteration
      logic publish;      // load the result register
   } crt_cmd_type;

   typedef struct packed {
      logic wrap_done;    // remaining counts fit without another overflow
      logic last_timer;
   } crt_status_type;

   // periods 1, 64, 256, 1024 expressed as shift amounts
   function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [1:0] sel);
      logic [SHIFT_W-1:0] sh;
      unique case (prescale_sel_type'(sel))
         PSC_DIV1:    sh = 4'd0;
         PSC_DIV64:   sh = 4'd6;
         PSC_DIV256:  sh = 4'd8;
         PSC_DIV1024: sh = 4'd10;
         default:     sh = 4'd0;
      endcase
      return sh;
   endfunction

endpackage

`default_nettype wire

### rtl/core/crt_ctrl.sv
// Controller FSM for the cascaded reload timer core: sequences the timers
// and owns the handshake state. Depends on crt_pkg.
`default_nettype none

module crt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   input  wire crt_pkg::crt_status_type sts,
   output crt_pkg::crt_cmd_type    cmd
);
   import crt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.begin_item = 1'b1;
               state_in       = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.step = 1'b1;
            if (sts.wrap_done) begin
               state_in = sts.last_timer ? ST_DELIVER : ST_SETUP;
            end
         end
         ST_DELIVER: begin
            // output register free or being drained this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/crt_datapath.sv
// Datapath of the cascaded reload timer core: config registers, per-timer
// counters and prescalers, the wrap iteration and the result register.
// Depends on crt_pkg.
`default_nettype none

module crt_datapath #(
   parameter int TIMER_COUNT = crt_pkg::DEFAULT_TIMER_COUNT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_write,
   input  wire  [crt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [crt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire  [crt_pkg::CYCLES_W-1:0]         req_elapsed_cycles,
   input  wire crt_pkg::crt_cmd_type            cmd,
   output crt_pkg::crt_status_type              sts,
   output logic [crt_pkg::IRQ_W-1:0]            rsp_irq_request_mask,
   output logic [crt_pkg::SOUND_W-1:0]          rsp_sound_overflow_mask,
   output logic [crt_pkg::COUNT_W-1:0]          rsp_count_zero,
   output logic [crt_pkg::COUNT_W-1:0]          rsp_count_one,
   output logic [crt_pkg::COUNT_W-1:0]          rsp_count_two,
   output logic [crt_pkg::COUNT_W-1:0]          rsp_count_three
);
   import crt_pkg::*;

   localparam int IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int OutTimers = 4;

   // configuration
   logic [COUNT_W-1:0]    reload_ff  [TIMER_COUNT];
   logic [CTRL_W-1:0]     control_ff [TIMER_COUNT];
   // timer state
   logic [PRESCALE_W-1:0] prescale_ff [TIMER_COUNT];
   logic [COUNT_W-1:0]    counter_ff  [TIMER_COUNT];
   logic                  running_ff  [TIMER_COUNT];
   // per-item work registers
   logic [IdxW-1:0]       idx_ff;
   logic [CYCLES_W-1:0]   cycles_ff;
   logic [SUM_W-1:0]      todo_ff;       // counts still to apply to current timer
   logic                  ovf_ff;        // current timer overflowed this item
   logic                  prev_ovf_ff;   // previous timer overflowed this item
   logic [IRQ_W-1:0]      irq_ff;
   logic [SOUND_W-1:0]    sound_ff;
   // result register
   logic [IRQ_W-1:0]      rsp_irq_ff;
   logic [SOUND_W-1:0]    rsp_sound_ff;
   logic [COUNT_W-1:0]    rsp_count_ff [OutTimers];

   logic                  csr_is_reload, csr_is_control;
   logic [1:0]            csr_timer;

   logic [CTRL_W-1:0]     ctrl_cur;
   logic [COUNT_W-1:0]    reload_cur, counter_cur;
   logic [PRESCALE_W-1:0] prescale_cur;
   logic                  running_cur;
   logic                  start, cascade, count_en;
   logic [PRESCALE_W-1:0] pc_base;
   logic [COUNT_W-1:0]    cnt_base;
   logic [SUM_W-1:0]      add_amt, psc_sum, psc_mask;
   logic [SHIFT_W-1:0]    shift;
   logic [COUNT_W-1:0]    space;
   logic [COUNT_W:0]      gap;
   logic                  fits;
   logic [COUNT_W-1:0]    cnt_view [OutTimers];

   always_comb begin
      csr_is_reload  = 1'b0;
      csr_is_control = 1'b0;
      unique case (csr_reg_type'(csr_index))
         REG_RELOAD_ZERO, REG_RELOAD_ONE, REG_RELOAD_TWO, REG_RELOAD_THREE:
            csr_is_reload = 1'b1;
         REG_CONTROL_ZERO, REG_CONTROL_ONE, REG_CONTROL_TWO, REG_CONTROL_THREE:
            csr_is_control = 1'b1;
         default: ;
      endcase
      csr_timer = csr_index[1:0];
   end

   // current timer view
   always_comb begin
      ctrl_cur     = control_ff[idx_ff];
      reload_cur   = reload_ff[idx_ff];
      counter_cur  = counter_ff[idx_ff];
      prescale_cur = prescale_ff[idx_ff];
      running_cur  = running_ff[idx_ff];

      start    = ctrl_cur[CTRL_START];
      cascade  = (idx_ff != '0) && ctrl_cur[CTRL_CASCADE];
      count_en = !cascade || prev_ovf_ff;
      pc_base  = running_cur ? prescale_cur : '0;
      cnt_base = running_cur ? counter_cur : reload_cur;
      add_amt  = cascade ? SUM_W'(1) : SUM_W'(cycles_ff);
      psc_sum  = SUM_W'(pc_base) + add_amt;
      shift    = prescale_shift(ctrl_cur[CTRL_SEL_HI:CTRL_SEL_LO]);
      psc_mask = ~({SUM_W{1'b1}} << shift);

      space = MAX_COUNT - counter_cur;
      gap   = {1'b0, space} + (COUNT_W+1)'(1);
      fits  = ((COUNT_W+1)'(todo_ff) <= {1'b0, space});
   end

   assign sts.wrap_done  = fits;
   assign sts.last_timer = (idx_ff == IdxW'(TIMER_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TIMER_COUNT; j++) begin
            reload_ff[j]   <= '0;
            control_ff[j]  <= '0;
            prescale_ff[j] <= '0;
            counter_ff[j]  <= '0;
            running_ff[j]  <= 1'b0;
         end
      end else begin
         for (int j = 0; j < TIMER_COUNT; j++) begin
            if (csr_write && (int'(csr_timer) == j)) begin
               if (csr_is_reload) begin
                  reload_ff[j] <= csr_wdata;
               end
               if (csr_is_control) begin
                  control_ff[j] <= csr_wdata[CTRL_W-1:0];
               end
            end
         end

         if (cmd.setup) begin
            if (start) begin
               running_ff[idx_ff] <= 1'b1;
               counter_ff[idx_ff] <= cnt_base;
               if (count_en) begin
                  prescale_ff[idx_ff] <= PRESCALE_W'(psc_sum & psc_mask);
               end else begin
                  prescale_ff[idx_ff] <= pc_base;
               end
            end else begin
               running_ff[idx_ff] <= 1'b0;
            end
         end

         if (cmd.step) begin
            if (fits) begin
               counter_ff[idx_ff] <= counter_cur + COUNT_W'(todo_ff);
            end else begin
               counter_ff[idx_ff] <= reload_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_item) begin
         cycles_ff   <= req_elapsed_cycles;
         idx_ff      <= '0;
         prev_ovf_ff <= 1'b0;
         irq_ff      <= '0;
         sound_ff    <= '0;
      end

      if (cmd.setup) begin
         ovf_ff  <= 1'b0;
         todo_ff <= (start && count_en) ? (psc_sum >> shift) : '0;
      end

      if (cmd.step) begin
         if (fits) begin
            // timer finished for this item
            prev_ovf_ff <= ovf_ff;
            for (int b = 0; b < IRQ_W; b++) begin
               if (int'(idx_ff) == b && ovf_ff && ctrl_cur[CTRL_IRQ]) begin
                  irq_ff[b] <= 1'b1;
               end
            end
            for (int b = 0; b < SOUND_W; b++) begin
               if (int'(idx_ff) == b && ovf_ff) begin
                  sound_ff[b] <= 1'b1;
               end
            end
            if (!sts.last_timer) begin
               idx_ff <= idx_ff + IdxW'(1);
            end
         end else begin
            todo_ff <= todo_ff - SUM_W'(gap);
            ovf_ff  <= 1'b1;
         end
      end

      if (cmd.publish) begin
         rsp_irq_ff   <= irq_ff;
         rsp_sound_ff <= sound_ff;
         for (int j = 0; j < OutTimers; j++) begin
            rsp_count_ff[j] <= cnt_view[j];
         end
      end
   end

   for (genvar j = 0; j < OutTimers; j++) begin : g_view
      if (j < TIMER_COUNT) begin : g_live
         assign cnt_view[j] = counter_ff[j];
      end else begin : g_absent
         assign cnt_view[j] = '0;
      end
   end

   assign rsp_irq_request_mask    = rsp_irq_ff;
   assign rsp_sound_overflow_mask = rsp_sound_ff;
   assign rsp_count_zero          = rsp_count_ff[0];
   assign rsp_count_one           = rsp_count_ff[1];
   assign rsp_count_two           = rsp_count_ff[2];
   assign rsp_count_three         = rsp_count_ff[3];

endmodule

`default_nettype wire

### rtl/core/cascaded_reload_timers_core.sv
// Four cascadable 16-bit reload timers with prescalers.
// Channels: req_* carries one tick transaction (elapsed_cycles); rsp_* returns
// one result transaction per tick with the irq and sound overflow masks and
// all four counts after the tick. Both use valid/stall; a transaction moves
// on a clock edge with valid high and stall low.
// csr_* writes a register: index 0..3 are the reload values, 4..7 the
// control registers. csr_ready is always high; write only while idle.
// Timers are processed one after another so a cascaded timer sees its
// predecessor's overflow. Each timer passes through a setup state, then
// repeats the wrap state for each counter overflow in the tick until the
// remaining counts fit, all done by a single shared wrap step. No new tick
// is accepted while timers are processed; the next can be accepted in the
// same cycle that the new result becomes valid.
// A finished result waits in the output register while the next tick is
// accepted; if rsp_stall still holds at the end of that tick, the core
// waits before delivering.
// Reset (synchronous) clears config, counters, prescalers, run flags and FSM state only.
// Depends on crt_pkg, crt_ctrl, crt_datapath.
`default_nettype none

module cascaded_reload_timers_core #(
   parameter int TIMER_COUNT = crt_pkg::DEFAULT_TIMER_COUNT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [crt_pkg::CYCLES_W-1:0]      req_elapsed_cycles,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [crt_pkg::IRQ_W-1:0]         rsp_irq_request_mask,
   output logic [crt_pkg::SOUND_W-1:0]       rsp_sound_overflow_mask,
   output logic [crt_pkg::COUNT_W-1:0]       rsp_count_zero,
   output logic [crt_pkg::COUNT_W-1:0]       rsp_count_one,
   output logic [crt_pkg::COUNT_W-1:0]       rsp_count_two,
   output logic [crt_pkg::COUNT_W-1:0]       rsp_count_three,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [crt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [crt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import crt_pkg::*;

   crt_cmd_type    cmd;
   crt_status_type sts;

   assign csr_ready = 1'b1;

   crt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   crt_datapath #(
      .TIMER_COUNT (TIMER_COUNT)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write               (csr_valid && csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_elapsed_cycles      (req_elapsed_cycles),
      .cmd                     (cmd),
      .sts                     (sts),
      .rsp_irq_request_mask    (rsp_irq_request_mask),
      .rsp_sound_overflow_mask (rsp_sound_overflow_mask),
      .rsp_count_zero          (rsp_count_zero),
      .rsp_count_one           (rsp_count_one),
      .rsp_count_two           (rsp_count_two),
      .rsp_count_three         (rsp_count_three)
   );

`ifndef SYNTHESIS
   // an accepted tick keeps the core busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core not busy after accepting a tick");

   // a new result only appears after a publish command
   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.publish))
      else $error("result appeared without publish");

   // an irq from timer 0 or 1 implies its overflow was flagged
   a_irq_implies_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_irq_request_mask[1:0] & ~rsp_sound_overflow_mask) == 2'b00))
      else $error("irq without overflow on timer 0 or 1");
`endif

endmodule

`default_nettype wire
